[rtl/uart_frame_password_parser_defines.svh]
// assertion macros used by the front end of the frame password parser
// needs aclk and aresetn in the scope of each use
`ifndef UART_FRAME_PASSWORD_PARSER_DEFINES_SVH
`define UART_FRAME_PASSWORD_PARSER_DEFINES_SVH

// property checked at every edge out of reset
`define UFPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition in one cycle implies a condition in the next
`define UFPP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/ufpp_pkg.sv]
// types and constants of the frame password parser
// used by every module of the block, no dependencies
package ufpp_pkg;

    localparam int BUF_DEPTH   = 32;
    localparam int MAX_PAYLOAD = 20;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int FILL_W      = $clog2(BUF_DEPTH + 1);
    localparam int FRAME_OVH   = 5;
    localparam int RESULT_CAP  = MAX_PAYLOAD + FRAME_OVH;
    localparam int CNT_W       = $clog2(RESULT_CAP + 1);
    localparam int MAX_DIGITS  = 12;
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'hBB;
    localparam logic [7:0] PWD_CMD     = 8'h50;
    localparam logic [7:0] PWD_MIN     = 8'd6;
    localparam logic [7:0] PWD_MAX     = 8'd12;
    localparam logic [7:0] DIGIT_LIMIT = 8'd10;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef struct packed {
        action_t                           action;
        logic [DIGIT_W-1:0]                pass_len;
        logic [MAX_DIGITS*DIGIT_W-1:0]     pass_digits;
        logic [7:0]                        echo_byte;
        logic                              last;
    } echo_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_CHK,
        ST_LEN_CHK,
        ST_SWP_RD,
        ST_SWP_ACC,
        ST_EVAL,
        ST_ECHO_RD,
        ST_ECHO_PUSH
    } scan_state_t;

endpackage

[rtl/ufpp_front.sv]
// front end: frame buffer memory and the scanner that validates frames
// depends on ufpp_pkg and the assertion macro header
`include "uart_frame_password_parser_defines.svh"

module ufpp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    output logic                q_push,
    output ufpp_pkg::echo_item_t q_item,
    input  logic                q_full
);

    logic [7:0]                    mem [ufpp_pkg::BUF_DEPTH];
    logic [7:0]                    rd_data_reg;
    logic [ufpp_pkg::ADDR_W-1:0]   rd_off;

    ufpp_pkg::scan_state_t         state_reg, state_next;
    logic [ufpp_pkg::ADDR_W-1:0]   head_reg, head_next;
    logic [ufpp_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [ufpp_pkg::FILL_W-1:0]   total_reg, total_next;
    logic [ufpp_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [7:0]                    xor_reg, xor_next;
    logic [7:0]                    chk_reg, chk_next;
    logic [7:0]                    tail_reg, tail_next;
    logic [7:0]                    cmd_reg, cmd_next;
    logic [7:0]                    p_reg, p_next;
    logic                          ok_reg, ok_next;
    logic [ufpp_pkg::MAX_DIGITS*ufpp_pkg::DIGIT_W-1:0] digits_reg, digits_next;
    ufpp_pkg::action_t             act_reg, act_next;
    logic [ufpp_pkg::CNT_W-1:0]    res_cnt_reg, res_cnt_next;

    logic                          accept;
    logic [ufpp_pkg::FILL_W-1:0]   idx_ext;
    logic [ufpp_pkg::FILL_W-1:0]   total_m1;
    logic [ufpp_pkg::FILL_W-1:0]   total_m2;
    logic [8:0]                    len9;
    logic [7:0]                    dig_pos;
    logic                          is_store;

    assign accept   = s_tvalid && s_tready;
    assign idx_ext  = ufpp_pkg::FILL_W'(idx_reg);
    assign total_m1 = total_reg - ufpp_pkg::FILL_W'(1);
    assign total_m2 = total_reg - ufpp_pkg::FILL_W'(2);
    assign len9     = {1'b0, rd_data_reg};
    assign dig_pos  = 8'(idx_reg) - 8'd4;

    // buffer is a ring: pointers wrap at the power-of-two depth
    always_ff @(posedge aclk) begin
        if (accept && (fill_reg < ufpp_pkg::FILL_W'(ufpp_pkg::BUF_DEPTH))) begin
            mem[head_reg + fill_reg[ufpp_pkg::ADDR_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[head_reg + rd_off];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ufpp_pkg::ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            res_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg  <= total_next;
        idx_reg    <= idx_next;
        xor_reg    <= xor_next;
        chk_reg    <= chk_next;
        tail_reg   <= tail_next;
        cmd_reg    <= cmd_next;
        p_reg      <= p_next;
        ok_reg     <= ok_next;
        digits_reg <= digits_next;
        act_reg    <= act_next;
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        xor_next     = xor_reg;
        chk_next     = chk_reg;
        tail_next    = tail_reg;
        cmd_next     = cmd_reg;
        p_next       = p_reg;
        ok_next      = ok_reg;
        digits_next  = digits_reg;
        act_next     = act_reg;
        res_cnt_next = res_cnt_reg;
        rd_off       = idx_reg;
        s_tready     = 1'b0;
        q_push       = 1'b0;
        is_store     = 1'b0;

        q_item.action      = (idx_reg == '0) ? act_reg : ufpp_pkg::ACT_NONE;
        q_item.pass_len    = (idx_reg == '0 && act_reg == ufpp_pkg::ACT_STORE)
                             ? p_reg[ufpp_pkg::DIGIT_W-1:0] : '0;
        q_item.pass_digits = (idx_reg == '0 && act_reg == ufpp_pkg::ACT_STORE)
                             ? digits_reg : '0;
        q_item.echo_byte   = rd_data_reg;
        q_item.last        = (idx_ext == total_m1);

        unique case (state_reg)
            ufpp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    if (fill_reg < ufpp_pkg::FILL_W'(ufpp_pkg::BUF_DEPTH)) begin
                        fill_next = fill_reg + ufpp_pkg::FILL_W'(1);
                    end
                    res_cnt_next = '0;
                    state_next   = ufpp_pkg::ST_HDR_RD;
                end
            end
            ufpp_pkg::ST_HDR_RD: begin
                rd_off = '0;
                if (fill_reg == '0) begin
                    state_next = ufpp_pkg::ST_IDLE;
                end else begin
                    state_next = ufpp_pkg::ST_HDR_CHK;
                end
            end
            ufpp_pkg::ST_HDR_CHK: begin
                rd_off = ufpp_pkg::ADDR_W'(1);
                if (rd_data_reg != ufpp_pkg::HDR_BYTE) begin
                    head_next  = head_reg + ufpp_pkg::ADDR_W'(1);
                    fill_next  = fill_reg - ufpp_pkg::FILL_W'(1);
                    state_next = ufpp_pkg::ST_HDR_RD;
                end else if (fill_reg < ufpp_pkg::FILL_W'(2)) begin
                    state_next = ufpp_pkg::ST_IDLE;
                end else begin
                    state_next = ufpp_pkg::ST_LEN_CHK;
                end
            end
            ufpp_pkg::ST_LEN_CHK: begin
                if ((len9 > 9'(ufpp_pkg::MAX_PAYLOAD)) ||
                    (len9 + 9'(ufpp_pkg::FRAME_OVH) > 9'(ufpp_pkg::BUF_DEPTH))) begin
                    head_next  = head_reg + ufpp_pkg::ADDR_W'(1);
                    fill_next  = fill_reg - ufpp_pkg::FILL_W'(1);
                    state_next = ufpp_pkg::ST_HDR_RD;
                end else begin
                    total_next = ufpp_pkg::FILL_W'(len9 + 9'(ufpp_pkg::FRAME_OVH));
                    if (fill_reg < ufpp_pkg::FILL_W'(len9 + 9'(ufpp_pkg::FRAME_OVH))) begin
                        state_next = ufpp_pkg::ST_IDLE;
                    end else begin
                        idx_next    = ufpp_pkg::ADDR_W'(1);
                        xor_next    = '0;
                        ok_next     = 1'b1;
                        digits_next = '0;
                        state_next  = ufpp_pkg::ST_SWP_RD;
                    end
                end
            end
            ufpp_pkg::ST_SWP_RD: begin
                state_next = ufpp_pkg::ST_SWP_ACC;
            end
            ufpp_pkg::ST_SWP_ACC: begin
                // one frame byte per visit: checksum, fields and digits
                if (idx_ext < total_m2) begin
                    xor_next = xor_reg ^ rd_data_reg;
                end
                if (idx_ext == total_m2) begin
                    chk_next = rd_data_reg;
                end
                if (idx_ext == total_m1) begin
                    tail_next = rd_data_reg;
                end
                if (idx_reg == ufpp_pkg::ADDR_W'(2)) begin
                    cmd_next = rd_data_reg;
                end
                if (idx_reg == ufpp_pkg::ADDR_W'(3)) begin
                    p_next = rd_data_reg;
                end
                if ((idx_reg >= ufpp_pkg::ADDR_W'(4)) && (dig_pos < p_reg)) begin
                    if (rd_data_reg >= ufpp_pkg::DIGIT_LIMIT) begin
                        ok_next = 1'b0;
                    end
                    for (int k = 0; k < ufpp_pkg::MAX_DIGITS; k++) begin
                        if (dig_pos == 8'(k)) begin
                            digits_next[k*ufpp_pkg::DIGIT_W +: ufpp_pkg::DIGIT_W] =
                                rd_data_reg[ufpp_pkg::DIGIT_W-1:0];
                        end
                    end
                end
                if (idx_ext == total_m1) begin
                    state_next = ufpp_pkg::ST_EVAL;
                end else begin
                    idx_next   = idx_reg + ufpp_pkg::ADDR_W'(1);
                    state_next = ufpp_pkg::ST_SWP_RD;
                end
            end
            ufpp_pkg::ST_EVAL: begin
                is_store = (p_reg >= ufpp_pkg::PWD_MIN) && (p_reg <= ufpp_pkg::PWD_MAX)
                           && ok_reg && (9'(p_reg) + 9'd4 <= 9'(total_reg));
                if ((tail_reg != ufpp_pkg::TAIL_BYTE) || (chk_reg != xor_reg)) begin
                    head_next  = head_reg + ufpp_pkg::ADDR_W'(1);
                    fill_next  = fill_reg - ufpp_pkg::FILL_W'(1);
                    state_next = ufpp_pkg::ST_HDR_RD;
                end else if (cmd_reg != ufpp_pkg::PWD_CMD) begin
                    head_next  = head_reg + total_reg[ufpp_pkg::ADDR_W-1:0];
                    fill_next  = fill_reg - total_reg;
                    state_next = ufpp_pkg::ST_HDR_RD;
                end else begin
                    if (p_reg == 8'd0) begin
                        act_next = ufpp_pkg::ACT_CLEAR;
                    end else if (is_store) begin
                        act_next = ufpp_pkg::ACT_STORE;
                    end else begin
                        act_next = ufpp_pkg::ACT_NONE;
                    end
                    idx_next   = '0;
                    state_next = ufpp_pkg::ST_ECHO_RD;
                end
            end
            ufpp_pkg::ST_ECHO_RD: begin
                state_next = ufpp_pkg::ST_ECHO_PUSH;
            end
            ufpp_pkg::ST_ECHO_PUSH: begin
                // past the per-item result cap the frame is consumed silently
                if (res_cnt_reg < ufpp_pkg::CNT_W'(ufpp_pkg::RESULT_CAP)) begin
                    if (!q_full) begin
                        q_push       = 1'b1;
                        res_cnt_next = res_cnt_reg + ufpp_pkg::CNT_W'(1);
                    end
                end
                if (q_push || (res_cnt_reg >= ufpp_pkg::CNT_W'(ufpp_pkg::RESULT_CAP))) begin
                    if (idx_ext == total_m1) begin
                        head_next  = head_reg + total_reg[ufpp_pkg::ADDR_W-1:0];
                        fill_next  = fill_reg - total_reg;
                        state_next = ufpp_pkg::ST_HDR_RD;
                    end else begin
                        idx_next   = idx_reg + ufpp_pkg::ADDR_W'(1);
                        state_next = ufpp_pkg::ST_ECHO_RD;
                    end
                end
            end
            default: begin
                state_next = ufpp_pkg::ST_IDLE;
            end
        endcase
    end

    `UFPP_ASSERT(a_fill_bound, fill_reg <= ufpp_pkg::FILL_W'(ufpp_pkg::BUF_DEPTH), "fill above depth")
    `UFPP_ASSERT(a_push_room, q_push |-> !q_full, "push into a full queue")
    `UFPP_ASSERT(a_result_cap, q_push |-> (res_cnt_reg < ufpp_pkg::CNT_W'(ufpp_pkg::RESULT_CAP)), "result cap exceeded")
    `UFPP_ASSERT_NEXT(a_scan_after_accept, accept, state_reg == ufpp_pkg::ST_HDR_RD, "no scan after item")

endmodule

[rtl/ufpp_queue.sv]
// short queue of echo items between scanner and output stage
// depends on ufpp_pkg
module ufpp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ufpp_pkg::echo_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output ufpp_pkg::echo_item_t pop_item,
    output logic                 empty
);

    ufpp_pkg::echo_item_t               slots [ufpp_pkg::QUEUE_DEPTH];
    logic [ufpp_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ufpp_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ufpp_pkg::Q_PTR_W:0]         count_reg, count_next;

    assign full     = (count_reg == (ufpp_pkg::Q_PTR_W + 1)'(ufpp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + ufpp_pkg::Q_PTR_W'(1);
        end
        if (pop && !empty) begin
            rd_ptr_next = rd_ptr_reg + ufpp_pkg::Q_PTR_W'(1);
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + (ufpp_pkg::Q_PTR_W + 1)'(1);
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - (ufpp_pkg::Q_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/ufpp_back.sv]
// back end: output register that drives the result stream from the queue
// depends on ufpp_pkg
module ufpp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ufpp_pkg::echo_item_t q_item,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic                 m_tlast
);

    ufpp_pkg::echo_item_t out_reg;
    logic                 valid_reg;

    // load when the register is empty or its item is being taken
    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, out_reg.echo_byte, out_reg.pass_digits,
                       out_reg.pass_len, out_reg.action};
    assign m_tlast  = out_reg.last;

endmodule

[rtl/uart_frame_password_parser.sv]
// Frame password parser: received bytes in, echoed password frames out.
// Input stream carries one byte per item on s_tdata[7:0]; s_tready is high
// only while the scanner is idle, one item at a time.
// Frames are 0xAA, length, command, payload, xor check, 0xBB. Bad bytes are
// dropped from the front of the buffer and the rest rescanned.
// Output stream gives one item per byte of a valid password frame; the
// first item carries action, length and digits, m_tlast marks the last byte.
// A complete frame is checked one byte at a time (single read port of the
// 32-byte buffer memory), then echoed one byte at a time while the queue
// has room; a rescan after a bad frame can walk the buffer several times.
// An echo item is pushed into the 4-deep queue and then loaded into the
// output register, which drives m_tvalid. A stalled receiver fills the
// queue and then holds the scanner; input is not taken until all results
// of the item are queued.
// Reset (aresetn low, synchronous) empties buffer, queue and output register.
// Buffer contents need no clearing pass.
// depends on ufpp_pkg, ufpp_front, ufpp_queue, ufpp_back
module uart_frame_password_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [1:0] action, [5:2] pass_len, [53:6] pass_digits,
                                   // [61:54] echo_byte, [63:62] zero
    output logic        m_tlast
);

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    ufpp_pkg::echo_item_t push_item;
    ufpp_pkg::echo_item_t pop_item;

    ufpp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_item   (push_item),
        .q_full   (q_full)
    );

    ufpp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    ufpp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (pop_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/sv/tb_uart_frame_password_parser.sv]
// self-checking bench for the frame password parser: byte stream in, echoed frames out
// keeps its own deframer model and compares every output item against it
// depends on ufpp_pkg and uart_frame_password_parser
`timescale 1ns / 1ps

module tb_uart_frame_password_parser;

    import ufpp_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 600;
    localparam int PHASE_BYTES = 75;

    typedef enum int {
        FRAME_OK,
        FRAME_BAD_CHECK,
        FRAME_BAD_TAIL
    } frame_fault_t;

    // deframer model plus the queue of echo items still owed by the block
    class echo_tracker;
        logic [7:0] held_bytes[$];
        echo_item_t echo_due[$];
        int         errors;

        function void take_rx_byte(logic [7:0] rx);
            int unsigned len, total, p, pos;
            logic [7:0]  chk;
            action_t     act;
            logic [3:0]  plen;
            logic [47:0] digits;
            bit          ok;
            echo_item_t  it;
            if (held_bytes.size() < BUF_DEPTH) begin
                held_bytes.push_back(rx);
            end
            while (held_bytes.size() > 0) begin
                if (held_bytes[0] != HDR_BYTE) begin
                    held_bytes.delete(0);
                    continue;
                end
                if (held_bytes.size() < 2) break;
                len = 32'(held_bytes[1]);
                if (len > MAX_PAYLOAD || len + FRAME_OVH > BUF_DEPTH) begin
                    held_bytes.delete(0);
                    continue;
                end
                total = len + FRAME_OVH;
                if (held_bytes.size() < total) break;
                chk = 8'h00;
                for (int unsigned i = 1; i < len + 3; i++) chk ^= held_bytes[i];
                if (held_bytes[len + 4] != TAIL_BYTE || held_bytes[len + 3] != chk) begin
                    held_bytes.delete(0);
                    continue;
                end
                if (held_bytes[2] == PWD_CMD) begin
                    act    = ACT_NONE;
                    plen   = '0;
                    digits = '0;
                    // with no payload the first payload slot is the check byte
                    p = 32'(held_bytes[3]);
                    if (p >= PWD_MIN && p <= PWD_MAX) begin
                        ok = 1'b1;
                        for (int unsigned i = 0; i < p; i++) begin
                            pos = 4 + i;
                            // a digit beyond the tail byte spoils the password
                            if (pos >= total || held_bytes[pos] >= DIGIT_LIMIT) begin
                                ok = 1'b0;
                                break;
                            end
                            digits[4*i +: 4] = held_bytes[pos][3:0];
                        end
                        if (ok) begin
                            act  = ACT_STORE;
                            plen = p[3:0];
                        end else begin
                            digits = '0;
                        end
                    end else if (p == 0) begin
                        act = ACT_CLEAR;
                    end
                    for (int unsigned i = 0; i < total; i++) begin
                        it.action      = (i == 0) ? act : ACT_NONE;
                        it.pass_len    = (i == 0) ? plen : '0;
                        it.pass_digits = (i == 0) ? digits : '0;
                        it.echo_byte   = held_bytes[i];
                        it.last        = (i + 1 == total);
                        echo_due.push_back(it);
                    end
                end
                for (int unsigned i = 0; i < total; i++) held_bytes.delete(0);
            end
        endfunction

        function void check_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_echo(logic [63:0] data, logic last_bit);
            echo_item_t want;
            if (echo_due.size() == 0) begin
                $error("echo item %0h arrived with nothing expected", data[61:54]);
                errors++;
                return;
            end
            want = echo_due.pop_front();
            check_field("action", 48'(want.action), 48'(data[1:0]));
            check_field("pass_len", 48'(want.pass_len), 48'(data[5:2]));
            check_field("pass_digits", want.pass_digits, data[53:6]);
            check_field("echo_byte", 48'(want.echo_byte), 48'(data[61:54]));
            check_field("pad", 48'h0, 48'(data[63:62]));
            check_field("last", 48'(want.last), 48'(last_bit));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    echo_tracker tracker;
    logic [7:0]  pay [0:31];
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int          inputs_taken;
    int          idle_cycles;

    uart_frame_password_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // accepted items on both sides, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.take_rx_byte(s_tdata);
                inputs_taken++;
            end
            if (m_tvalid && m_tready) begin
                tracker.match_echo(m_tdata, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("FAIL uart_frame_password_parser");
            $finish;
        end
    end

    // receiver side: random stalls, plus one long hold when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // called at a falling edge, returns at a falling edge with the item taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] len_b, input logic [7:0] cmd,
                              input int npay, input frame_fault_t fault);
        logic [7:0] chk;
        chk = len_b ^ cmd;
        send_byte(HDR_BYTE);
        send_byte(len_b);
        send_byte(cmd);
        for (int i = 0; i < npay; i++) begin
            chk ^= pay[i];
            send_byte(pay[i]);
        end
        send_byte(fault == FRAME_BAD_CHECK ? chk ^ 8'($urandom_range(1, 255)) : chk);
        send_byte(fault == FRAME_BAD_TAIL ? TAIL_BYTE ^ 8'($urandom_range(1, 255))
                                          : TAIL_BYTE);
    endtask

    function automatic void fill_random(int from, int upto);
        for (int i = from; i < upto; i++) pay[i] = 8'($urandom);
    endfunction

    // password length p, then digits, then random filler up to npay bytes
    function automatic void load_password(int p, int npay);
        pay[0] = 8'(p);
        for (int i = 1; i < npay; i++) begin
            pay[i] = (i <= p) ? 8'($urandom_range(0, 9)) : 8'($urandom);
        end
    endfunction

    task automatic wait_drained;
        while (tracker.echo_due.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int p, npay, pick, target, frame_no;
        tracker       = new;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        hold_req      = 1'b0;
        inputs_taken  = 0;
        idle_cycles   = 0;
        send_idle_pct = 11;
        recv_idle_pct = 53;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // directed cases
        send_byte(8'h00);
        send_byte(8'hFF);
        load_password(6, 7);
        send_frame(7, PWD_CMD, 7, FRAME_OK);
        load_password(12, 13);
        pay[1]  = 8'd0;
        pay[12] = 8'd9;
        send_frame(13, PWD_CMD, 13, FRAME_OK);
        pay[0] = 8'd0;
        send_frame(1, PWD_CMD, 1, FRAME_OK);
        send_frame(0, PWD_CMD, 0, FRAME_OK);
        load_password(6, 7);
        pay[4] = DIGIT_LIMIT;
        send_frame(7, PWD_CMD, 7, FRAME_OK);
        load_password(13, 14);
        send_frame(14, PWD_CMD, 14, FRAME_OK);
        load_password(5, 6);
        send_frame(6, PWD_CMD, 6, FRAME_OK);
        // password runs past the tail byte
        load_password(6, 3);
        send_frame(3, PWD_CMD, 3, FRAME_OK);
        load_password(12, MAX_PAYLOAD);
        send_frame(8'(MAX_PAYLOAD), PWD_CMD, MAX_PAYLOAD, FRAME_OK);
        load_password(8, 9);
        send_frame(9, 8'h51, 9, FRAME_OK);
        load_password(6, 7);
        send_frame(7, PWD_CMD, 7, FRAME_BAD_CHECK);
        send_frame(7, PWD_CMD, 7, FRAME_BAD_TAIL);
        pay[0] = 8'd0;
        send_frame(8'(MAX_PAYLOAD + 1), PWD_CMD, 2, FRAME_OK);
        send_frame(8'hFF, PWD_CMD, 0, FRAME_OK);
        // stray header in front of a good frame
        send_byte(HDR_BYTE);
        load_password(7, 8);
        send_frame(8, PWD_CMD, 8, FRAME_OK);
        s_tvalid = 1'b0;
        wait_drained;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 11 : 0;
            target   = inputs_taken + PHASE_BYTES;
            frame_no = 0;
            while (inputs_taken < target) begin
                // long receiver hold while frames keep coming
                if (phase == 0 && frame_no == 1) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    p    = $urandom_range(PWD_MIN, PWD_MAX);
                    npay = $urandom_range(p + 1, MAX_PAYLOAD);
                    load_password(p, npay);
                    if ($urandom_range(0, 9) == 0) begin
                        pay[$urandom_range(1, p)] = 8'($urandom_range(DIGIT_LIMIT, 255));
                    end
                    send_frame(8'(npay), PWD_CMD, npay, FRAME_OK);
                end else if (pick < 55) begin
                    npay = $urandom_range(1, MAX_PAYLOAD);
                    fill_random(1, npay);
                    pay[0] = 8'd0;
                    send_frame(8'(npay), PWD_CMD, npay, FRAME_OK);
                end else if (pick < 62) begin
                    npay = $urandom_range(0, MAX_PAYLOAD);
                    fill_random(0, npay);
                    if (npay > 0 && $urandom_range(0, 1)) pay[0] = 8'($urandom_range(0, 14));
                    send_frame(8'(npay), PWD_CMD, npay, FRAME_OK);
                end else if (pick < 75) begin
                    npay = $urandom_range(0, MAX_PAYLOAD);
                    fill_random(0, npay);
                    send_frame(8'(npay), 8'($urandom), npay, FRAME_OK);
                end else if (pick < 87) begin
                    p    = $urandom_range(PWD_MIN, PWD_MAX);
                    npay = $urandom_range(p + 1, MAX_PAYLOAD);
                    load_password(p, npay);
                    send_frame(8'(npay), PWD_CMD, npay,
                               $urandom_range(0, 1) ? FRAME_BAD_CHECK : FRAME_BAD_TAIL);
                end else if (pick < 93) begin
                    npay = $urandom_range(0, 6);
                    fill_random(0, npay);
                    send_frame(8'($urandom_range(MAX_PAYLOAD + 1, 255)), PWD_CMD, npay,
                               FRAME_OK);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                frame_no++;
            end
            s_tvalid = 1'b0;
            wait_drained;
        end

        repeat (SETTLE) @(posedge aclk);
        if (tracker.echo_due.size() != 0) begin
            $error("%0d echo items never arrived", tracker.echo_due.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("PASS uart_frame_password_parser");
        end else begin
            $display("FAIL uart_frame_password_parser");
        end
        $finish;
    end

endmodule
